// File: design/region_decoded_big_endian_memory_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef REGION_DECODED_BIG_ENDIAN_MEMORY_ASSERT_SVH
`define REGION_DECODED_BIG_ENDIAN_MEMORY_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define RDBEM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rdbem assertion failed");

// Next-cycle implication, off while reset is asserted.
`define RDBEM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rdbem assertion failed");

// Next-cycle implication that also holds across reset.
`define RDBEM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rdbem assertion failed");

`endif

// File: design/rdbem_pkg.sv
package rdbem_pkg;

  // Address split
  localparam int OFFSET_BITS = 20;
  localparam int REGION_BITS = 12;
  localparam int ROW_BITS    = OFFSET_BITS - 2;
  localparam int NUM_LANES   = 4;

  // Clearing sweep covers three stores of 2^ROW_BITS rows
  localparam logic [OFFSET_BITS-1:0] CLEAR_LAST =
    OFFSET_BITS'(3 * (1 << ROW_BITS) - 1);

  // Register reset values
  localparam logic [REGION_BITS-1:0] PROG_SEL_RST  = 12'h004;
  localparam logic [REGION_BITS-1:0] DATA_SEL_RST  = 12'h100;
  localparam logic [REGION_BITS-1:0] STACK_SEL_RST = 12'h7FF;

  // Configuration register indexes
  localparam logic [1:0] CFG_PROG  = 2'd0;
  localparam logic [1:0] CFG_DATA  = 2'd1;
  localparam logic [1:0] CFG_STACK = 2'd2;

  // Store identifiers, top bits of the lane memory address
  localparam logic [1:0] STORE_PROG  = 2'd0;
  localparam logic [1:0] STORE_DATA  = 2'd1;
  localparam logic [1:0] STORE_STACK = 2'd2;

  // Access codes
  localparam logic [1:0] MD_READ  = 2'd0;
  localparam logic [1:0] MD_WRITE = 2'd1;
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_UNMAPPED = 3'd1,
    STAT_BAD_SIZE = 3'd2,
    STAT_BAD_MODE = 3'd3,
    STAT_PAST_END = 3'd4
  } status_t;

  typedef enum logic {
    S_CLEAR,
    S_RUN
  } state_t;

  // Decoded access: result fields plus per-lane memory requests
  typedef struct packed {
    status_t                                 status;
    logic                                    mis;
    logic                                    rd_ok;
    logic [1:0]                              lo;
    logic [1:0]                              last;
    logic [NUM_LANES-1:0]                    we;
    logic [NUM_LANES-1:0][7:0]               wd;
    logic [NUM_LANES-1:0][OFFSET_BITS-1:0]   addr;
  } acc_t;

  // Fields held while the lane memories return read data
  typedef struct packed {
    status_t    status;
    logic       mis;
    logic       rd_ok;
    logic [1:0] lo;
    logic [1:0] last;
  } meta_t;

endpackage

// File: design/region_decoded_big_endian_memory.sv
// Region-decoded big-endian byte memory.
// Input channel (in_valid/in_ready) carries one access: address, write_data,
// mode and size. Address bits above the offset pick the program, data or
// stack store by the three select registers; the low offset bits address
// bytes. Half and word accesses are big-endian and may be misaligned.
// Result channel (out_valid/out_ready) returns read_data, status and
// misaligned, one result per access, in order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the select registers; cfg_ready is always high, index 3 is ignored.
// The three stores share four byte-lane memories; every access reads or
// writes all lanes it touches in the cycle it is accepted, so one access per
// cycle is sustained while the result channel does not stall. An accepted
// access passes the read stage and then the output register to out_valid.
// A stalled receiver holds the output register; one further access stays in
// the read stage, after which in_ready drops.
// After reset a clearing pass zeroes the stores one row per cycle, covering
// three stores of 2^18 rows; in_ready stays low meanwhile.
module region_decoded_big_endian_memory
  import rdbem_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_address,
  input  logic [31:0]            in_write_data,
  input  logic [1:0]             in_mode,
  input  logic [1:0]             in_size,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_read_data,
  output logic [2:0]             out_status,
  output logic                   out_misaligned,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [REGION_BITS-1:0] cfg_data
);

  state_t                 state_r, state_nxt;
  logic [OFFSET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [REGION_BITS-1:0] prog_sel_r, data_sel_r, stack_sel_r;
  logic                   clearing;
  logic                   in_accept;
  logic                   s1_valid_r, s1_valid_nxt;
  meta_t                  s1_meta_r;
  logic                   s1_adv;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_read_data_r;
  logic [2:0]             out_status_r;
  logic                   out_mis_r;
  logic [31:0]            rdata;
  acc_t                   acc;
  logic [NUM_LANES-1:0][7:0] lane_rd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_sel_r  <= PROG_SEL_RST;
      data_sel_r  <= DATA_SEL_RST;
      stack_sel_r <= STACK_SEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROG:  prog_sel_r  <= cfg_data;
        CFG_DATA:  data_sel_r  <= cfg_data;
        CFG_STACK: stack_sel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clear sequencer: next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLEAR_LAST) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: ;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Clear sequencer: outputs
  always_comb begin
    unique case (state_r)
      S_CLEAR: clearing = 1'b1;
      S_RUN:   clearing = 1'b0;
      default: clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Accept while not clearing and the read stage is free or moving on
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clearing && (!s1_valid_r || s1_adv);
  assign in_accept = in_valid && in_ready;

  rdbem_decode u_decode (
    .address    (in_address),
    .write_data (in_write_data),
    .mode       (in_mode),
    .size       (in_size),
    .prog_sel   (prog_sel_r),
    .data_sel   (data_sel_r),
    .stack_sel  (stack_sel_r),
    .acc        (acc)
  );

  // Byte-lane memories, cleared by the sweep, accessed on each transfer
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rdbem_ram #(
      .AW (OFFSET_BITS),
      .DW (8)
    ) u_ram (
      .clk  (clk),
      .addr (clearing ? clr_cnt_r : acc.addr[l]),
      .we   (clearing || (in_accept && acc.we[l])),
      .wd   (clearing ? 8'h00 : acc.wd[l]),
      .re   (in_accept),
      .rd   (lane_rd[l])
    );
  end

  // Read stage
  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta_r <= '{status: acc.status, mis: acc.mis, rd_ok: acc.rd_ok,
                     lo: acc.lo, last: acc.last};
    end
  end

  // Join lane bytes big-endian and zero-extend
  always_comb begin
    logic [1:0] idx;
    rdata = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      idx = 2'(l) - s1_meta_r.lo;
      if (idx <= s1_meta_r.last) begin
        rdata = rdata | (32'(lane_rd[l]) << {s1_meta_r.last - idx, 3'b000});
      end
    end
    if (!s1_meta_r.rd_ok) begin
      rdata = '0;
    end
  end

  // Output register
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_read_data_r <= rdata;
      out_status_r    <= s1_meta_r.status;
      out_mis_r       <= s1_meta_r.mis;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_status     = out_status_r;
  assign out_misaligned = out_mis_r;

endmodule

// File: design/rdbem_ram.sv
module rdbem_ram #(
  parameter int AW = 20,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wd,
  input  logic          re,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rd_r;

  // Write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wd;
    end
    if (re) begin
      rd_r <= mem_r[addr];
    end
  end

  assign rd = rd_r;

endmodule

// File: design/rdbem_decode.sv
module rdbem_decode
  import rdbem_pkg::*;
(
  input  logic [31:0]            address,
  input  logic [31:0]            write_data,
  input  logic [1:0]             mode,
  input  logic [1:0]             size,
  input  logic [REGION_BITS-1:0] prog_sel,
  input  logic [REGION_BITS-1:0] data_sel,
  input  logic [REGION_BITS-1:0] stack_sel,
  output acc_t                   acc
);

  logic [REGION_BITS-1:0] region;
  logic [OFFSET_BITS-1:0] offset;
  logic [ROW_BITS-1:0]    base_row;
  logic [OFFSET_BITS:0]   end_sum;
  logic [1:0]             store;
  logic                   mapped;
  logic [1:0]             last;
  logic                   mis;
  logic                   is_write;
  status_t                status;

  assign region   = address[OFFSET_BITS +: REGION_BITS];
  assign offset   = address[OFFSET_BITS-1:0];
  assign base_row = offset[OFFSET_BITS-1:2];
  assign is_write = (mode == MD_WRITE);

  // Pick the store, program first, then data, then stack
  always_comb begin
    mapped = 1'b1;
    store  = STORE_PROG;
    if (region == prog_sel) begin
      store = STORE_PROG;
    end else if (region == data_sel) begin
      store = STORE_DATA;
    end else if (region == stack_sel) begin
      store = STORE_STACK;
    end else begin
      mapped = 1'b0;
    end
  end

  // Index of the last byte of the access
  always_comb begin
    case (size)
      SZ_HALF: last = 2'd1;
      SZ_WORD: last = 2'd3;
      default: last = 2'd0;
    endcase
  end

  assign mis = ((size == SZ_HALF) && offset[0]) ||
               ((size == SZ_WORD) && (offset[1:0] != 2'd0));

  // Last byte beyond the store sets the carry bit
  assign end_sum = {1'b0, offset} + (OFFSET_BITS+1)'(last);

  // Status in priority order
  always_comb begin
    if (!mapped) begin
      status = STAT_UNMAPPED;
    end else if (size == 2'd3) begin
      status = STAT_BAD_SIZE;
    end else if (mode != MD_READ && mode != MD_WRITE) begin
      status = STAT_BAD_MODE;
    end else if (end_sum[OFFSET_BITS]) begin
      status = STAT_PAST_END;
    end else begin
      status = STAT_OK;
    end
  end

  // Route each access byte to its lane; byte zero is most significant
  always_comb begin
    logic [1:0] idx;
    logic [4:0] sh;
    logic       hit;
    logic       carry;
    acc.status = status;
    acc.mis    = mis && (status != STAT_UNMAPPED) && (status != STAT_BAD_SIZE);
    acc.rd_ok  = (status == STAT_OK) && !is_write;
    acc.lo     = offset[1:0];
    acc.last   = last;
    for (int l = 0; l < NUM_LANES; l++) begin
      idx   = 2'(l) - offset[1:0];
      hit   = (idx <= last);
      sh    = {last - idx, 3'b000};
      carry = (2'(l) < offset[1:0]);
      acc.we[l]   = (status == STAT_OK) && is_write && hit;
      acc.wd[l]   = 8'(write_data >> sh);
      acc.addr[l] = {store, base_row + ROW_BITS'(carry)};
    end
  end

endmodule

// File: design/rdbem_checker.sv
`include "region_decoded_big_endian_memory_assert.svh"

module rdbem_checker
  import rdbem_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic [2:0]  out_status,
  input logic        out_misaligned
);

  // Stalled result holds its value
  `RDBEM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_read_data) && $stable(out_status))

  // Failed access returns no data
  `RDBEM_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (out_status != STAT_OK),
    out_read_data == 32'd0)

  // Alignment not reported for unmapped region or bad size
  `RDBEM_ASSERT_IMP(a_mis_mask, clk, rst_n,
    out_valid && ((out_status == STAT_UNMAPPED) || (out_status == STAT_BAD_SIZE)),
    !out_misaligned)

  // Reset empties the pipeline and starts the clearing pass
  `RDBEM_ASSERT_NXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_valid && !in_ready)

endmodule

bind region_decoded_big_endian_memory rdbem_checker u_rdbem_checker (.*);

// File: tb/tb_top.sv
module tb_top;
  import rdbem_pkg::*;

  // Codes outside the package: invalid mode and size, ignored register index
  localparam logic [1:0] MD_INVALID_2 = 2'd2;
  localparam logic [1:0] MD_INVALID_3 = 2'd3;
  localparam logic [1:0] SZ_INVALID   = 2'd3;
  localparam logic [1:0] CFG_NONE     = 2'd3;

  localparam int STORE_BYTES  = 1 << OFFSET_BITS;
  localparam int CLEAR_CYCLES = 3 * (1 << ROW_BITS);
  localparam int CYCLE_LIMIT  = 4 * CLEAR_CYCLES + 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  mode;
    logic [1:0]  size;
  } mem_access_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
    logic        misaligned;
  } mem_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            in_address = '0;
  logic [31:0]            in_write_data = '0;
  logic [1:0]             in_mode = '0;
  logic [1:0]             in_size = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [31:0]            out_read_data;
  logic [2:0]             out_status;
  logic                   out_misaligned;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [REGION_BITS-1:0] cfg_data = '0;

  // Shadow of the three stores, keyed by {store id, byte offset}
  bit [7:0] shadow_bytes [bit [OFFSET_BITS+1:0]];
  logic [REGION_BITS-1:0] sel_prog  = PROG_SEL_RST;
  logic [REGION_BITS-1:0] sel_data  = DATA_SEL_RST;
  logic [REGION_BITS-1:0] sel_stack = STACK_SEL_RST;

  mem_access_t pending_accesses [$];
  mem_result_t expected_results [$];
  int accesses_queued = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_len        = 0;
  int hold_tag        = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycle_count     = 0;

  region_decoded_big_endian_memory uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_mode        (in_mode),
    .in_size        (in_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .out_misaligned (out_misaligned),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Track a select register write; unknown indexes leave everything alone
  function automatic void note_select(logic [1:0] idx, logic [REGION_BITS-1:0] val);
    case (idx)
      CFG_PROG:  sel_prog = val;
      CFG_DATA:  sel_data = val;
      CFG_STACK: sel_stack = val;
      default: ;
    endcase
  endfunction

  function automatic bit [7:0] shadow_read(bit [OFFSET_BITS+1:0] key);
    return shadow_bytes.exists(key) ? shadow_bytes[key] : 8'h00;
  endfunction

  // Carry out one access on the shadow stores and return its result
  function automatic mem_result_t perform_access(mem_access_t a);
    mem_result_t r;
    logic [REGION_BITS-1:0] region;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] byte_off;
    logic [1:0] sid;
    bit mapped;
    int nbytes;
    int i;
    r.read_data  = '0;
    r.status     = STAT_OK;
    r.misaligned = 1'b0;
    region = a.address[31:OFFSET_BITS];
    offset = a.address[OFFSET_BITS-1:0];
    mapped = 1'b1;
    sid = STORE_PROG;
    // program beats data beats stack when selects overlap
    if (region == sel_prog) sid = STORE_PROG;
    else if (region == sel_data) sid = STORE_DATA;
    else if (region == sel_stack) sid = STORE_STACK;
    else mapped = 1'b0;
    if (!mapped) begin
      r.status = STAT_UNMAPPED;
    end else if (a.size == SZ_INVALID) begin
      r.status = STAT_BAD_SIZE;
    end else begin
      nbytes = 1 << a.size;
      r.misaligned = (a.address[1:0] & 2'(nbytes - 1)) != 2'b00;
      if (a.mode != MD_READ && a.mode != MD_WRITE) begin
        r.status = STAT_BAD_MODE;
      end else if (int'(offset) + nbytes > STORE_BYTES) begin
        r.status = STAT_PAST_END;
      end else if (a.mode == MD_READ) begin
        for (i = 0; i < nbytes; i++) begin
          byte_off = offset + OFFSET_BITS'(i);
          r.read_data = {r.read_data[23:0], shadow_read({sid, byte_off})};
        end
      end else begin
        // big-endian: lowest offset takes the most significant byte
        for (i = 0; i < nbytes; i++) begin
          byte_off = offset + OFFSET_BITS'(i);
          shadow_bytes[{sid, byte_off}] = a.write_data[8 * (nbytes - 1 - i) +: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_access(logic [31:0] addr, logic [31:0] wdata,
                                       logic [1:0] mode, logic [1:0] size);
    mem_access_t a;
    a.address    = addr;
    a.write_data = wdata;
    a.mode       = mode;
    a.size       = size;
    pending_accesses.push_back(a);
    accesses_queued++;
  endfunction

  // Mostly mapped regions, offsets near both ends of a store
  function automatic void queue_random_access();
    logic [REGION_BITS-1:0] region;
    logic [OFFSET_BITS-1:0] offset;
    logic [1:0] mode;
    logic [1:0] size;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) region = sel_prog;
    else if (pick < 55) region = sel_data;
    else if (pick < 80) region = sel_stack;
    else region = REGION_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) offset = OFFSET_BITS'($urandom_range(0, 63));
    else if (pick < 75) offset = OFFSET_BITS'(STORE_BYTES - $urandom_range(1, 8));
    else offset = OFFSET_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) mode = MD_READ;
    else if (pick < 90) mode = MD_WRITE;
    else if (pick < 95) mode = MD_INVALID_2;
    else mode = MD_INVALID_3;
    pick = $urandom_range(0, 99);
    if (pick < 30) size = SZ_BYTE;
    else if (pick < 60) size = SZ_HALF;
    else if (pick < 90) size = SZ_WORD;
    else size = SZ_INVALID;
    queue_access({region, offset}, $urandom, mode, size);
  endfunction

  task automatic write_select(input logic [1:0] idx, input logic [REGION_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    note_select(idx, val);
  endtask

  task automatic set_selects(input logic [REGION_BITS-1:0] p, input logic [REGION_BITS-1:0] d,
                             input logic [REGION_BITS-1:0] s);
    write_select(CFG_PROG, p);
    write_select(CFG_DATA, d);
    write_select(CFG_STACK, s);
    write_select(CFG_NONE, REGION_BITS'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_seen < accesses_queued) @(posedge clk);
  endtask

  // Offer half, pause until every result is back, then offer the rest
  task automatic run_random(input int count);
    int i;
    for (i = 0; i < count / 2; i++) queue_random_access();
    wait_drained();
    for (i = count / 2; i < count; i++) queue_random_access();
    wait_drained();
  endtask

  // Sender: hold a waiting transfer, otherwise offer the next access or idle
  always @(posedge clk) begin
    mem_access_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item.address    = in_address;
        item.write_data = in_write_data;
        item.mode       = in_mode;
        item.size       = in_size;
        expected_results.push_back(perform_access(item));
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_accesses.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        item = pending_accesses.pop_front();
        in_valid      <= 1'b1;
        in_address    <= item.address;
        in_write_data <= item.write_data;
        in_mode       <= item.mode;
        in_size       <= item.size;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off first, then random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    mem_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_data %h status %0d misaligned %0b",
               out_read_data, out_status, out_misaligned);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_read_data);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_misaligned !== want.misaligned) begin
          $error("misaligned: expected %0b, got %0b", want.misaligned, out_misaligned);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit, covering the clearing sweep after reset
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("region_decoded_big_endian_memory: mismatch");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset selects, sender idles little, receiver a lot
    send_idle_pct = 16;
    recv_idle_pct = 72;
    set_selects(PROG_SEL_RST, DATA_SEL_RST, STACK_SEL_RST);

    // Directed: lanes and endianness, store ends, each error and its priority
    queue_access(32'h0040_0000, 32'hA1B2_C3D4, MD_WRITE, SZ_WORD);
    queue_access(32'h0040_0000, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h0040_0001, 32'h0000_0000, MD_READ, SZ_BYTE);
    queue_access(32'h0040_0002, 32'h0000_0000, MD_READ, SZ_HALF);
    queue_access(32'h0040_0001, 32'h0000_0000, MD_READ, SZ_HALF);
    queue_access(32'h0040_0003, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h1000_0003, 32'hFFFF_1234, MD_WRITE, SZ_HALF);
    queue_access(32'h1000_0002, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h7FFF_FFFF, 32'hFFFF_FFFF, MD_WRITE, SZ_BYTE);
    queue_access(32'h7FFF_FFFF, 32'h0000_0000, MD_READ, SZ_BYTE);
    queue_access(32'h7FFF_FFFC, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h7FFF_FFFD, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h7FFF_FFFF, 32'hFFFF_FFFF, MD_WRITE, SZ_HALF);
    queue_access(32'h004F_FFFE, 32'hFFFF_FFFF, MD_WRITE, SZ_WORD);
    queue_access(32'h004F_FFFE, 32'h0000_0000, MD_READ, SZ_HALF);
    queue_access(32'h0000_0001, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, MD_WRITE, SZ_WORD);
    queue_access(32'h0040_0001, 32'hFFFF_FFFF, MD_INVALID_2, SZ_INVALID);
    queue_access(32'h0040_0001, 32'hFFFF_FFFF, MD_INVALID_2, SZ_HALF);
    queue_access(32'h0040_0000, 32'hFFFF_FFFF, MD_INVALID_3, SZ_WORD);
    queue_access(32'h0040_0000, 32'h0000_0000, MD_READ, SZ_WORD);
    queue_access(32'h1000_0000, 32'h0000_0000, MD_WRITE, SZ_WORD);
    queue_access(32'h7FF0_0000, 32'h0000_005A, MD_WRITE, SZ_BYTE);
    queue_access(32'h7FF0_0000, 32'h0000_0000, MD_READ, SZ_BYTE);
    wait_drained();
    run_random(300);

    // Extreme select values
    set_selects(12'h000, 12'hFFF, 12'h800);
    run_random(300);

    // Sender idles a lot, receiver little; overlapping selects
    send_idle_pct = 72;
    recv_idle_pct = 16;
    set_selects(12'h123, 12'h123, 12'h123);
    run_random(250);
    set_selects(12'h555, 12'h0AA, 12'h0AA);
    run_random(250);
    set_selects(REGION_BITS'($urandom), REGION_BITS'($urandom), REGION_BITS'($urandom));
    run_random(300);

    // No idling; receiver holds off long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_selects(12'hFFF, 12'h000, 12'h001);
    hold_len = HOLD_CYCLES;
    hold_tag++;
    run_random(300);
    run_random(300);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("region_decoded_big_endian_memory: match");
    end else begin
      $display("region_decoded_big_endian_memory: mismatch");
    end
    $finish;
  end

endmodule

// File: region_decoded_big_endian_memory.f
+incdir+design
design/rdbem_pkg.sv
design/rdbem_ram.sv
design/rdbem_decode.sv
design/region_decoded_big_endian_memory.sv
design/rdbem_checker.sv
tb/tb_top.sv
